### sv/asps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asps_pkg
// Shared types, constants and scoring functions for the alignment column
// sum-of-pairs scorer.
// ----------------------------------------------------------------------------
package asps_pkg;

  // Field widths.
  localparam int BASE_W   = 7;
  localparam int GAPE_W   = 10;
  localparam int GAPO_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  localparam int COL_W    = 17;
  localparam int TOT_W    = 48;

  // One pair score spans -1023 - 4095 up to +100.
  localparam int PAIR_W   = 14;
  // A column sum over at most 28 pairs stays within 19 signed bits.
  localparam int SUM_W    = 19;

  localparam int MAX_ROWS_DEF = 8;
  localparam int ROW_CNT  = 8;

  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_EXTEND   = 2'd0,
    CFG_OPEN_PENALTY = 2'd1
  } cfg_idx_t;

  localparam logic [GAPE_W-1:0] GAP_EXTEND_RST   = 10'd30;
  localparam logic [GAPO_W-1:0] OPEN_PENALTY_RST = 12'd400;

  // Character codes.
  localparam logic [BASE_W-1:0] CH_DASH = 7'h2D;
  localparam logic [BASE_W-1:0] CH_X_UP = 7'h58;
  localparam logic [BASE_W-1:0] CH_X_LO = 7'h78;

  // Fixed scores for the cases outside the nucleotide table.
  localparam pair_t SCORE_OTHER = -14'sd100;
  localparam pair_t SCORE_X     = -14'sd1000;

  // Dash pattern {prev_r, prev_s, cur_r, cur_s} codes that open a gap:
  // 1, 2, 6, 9, 13 and 14.
  localparam logic [15:0] GAP_PAT_MASK = 16'h6246;

  // Substitution table for A, C, G, T.
  localparam pair_t HOX_TAB [4][4] = '{
    '{  14'sd91, -14'sd114,  -14'sd31, -14'sd123 },
    '{ -14'sd114,  14'sd100, -14'sd125,  -14'sd31 },
    '{  -14'sd31, -14'sd125,  14'sd100, -14'sd114 },
    '{ -14'sd123,  -14'sd31, -14'sd114,   14'sd91 }
  };

  // Control for one pair lane.
  typedef struct packed {
    logic ld;
    logic scored;
    logic first;
  } lane_ctl_t;

  // Load enables for the two merge stages.
  typedef struct packed {
    logic ld_grp;
    logic ld_sum;
  } merge_ctl_t;

  // Nucleotide code: bit 2 is valid, bits 1:0 the table index.
  function automatic logic [2:0] nuc_code(input logic [BASE_W-1:0] c);
    logic [2:0] code;
    case (c) inside
      7'h41, 7'h61: code = 3'b100;
      7'h43, 7'h63: code = 3'b101;
      7'h47, 7'h67: code = 3'b110;
      7'h54, 7'h74: code = 3'b111;
      default:      code = 3'b000;
    endcase
    return code;
  endfunction

  // Substitution score of one character pair, dash taking precedence.
  function automatic pair_t pair_subst(input logic [BASE_W-1:0] a,
                                       input logic [BASE_W-1:0] b,
                                       input logic [GAPE_W-1:0] gap_extend);
    logic [2:0] ca;
    logic [2:0] cb;
    pair_t      res;
    ca = nuc_code(a);
    cb = nuc_code(b);
    if (a == CH_DASH || b == CH_DASH) begin
      if (a == CH_DASH && b == CH_DASH) begin
        res = '0;
      end else begin
        res = pair_t'(0) - pair_t'({{(PAIR_W-GAPE_W){1'b0}}, gap_extend});
      end
    end else if (a == CH_X_UP || a == CH_X_LO || b == CH_X_UP || b == CH_X_LO) begin
      res = SCORE_X;
    end else if (!ca[2] || !cb[2]) begin
      res = SCORE_OTHER;
    end else begin
      res = HOX_TAB[ca[1:0]][cb[1:0]];
    end
    return res;
  endfunction

endpackage

### sv/alignment_column_sum_of_pairs_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alignment_column_sum_of_pairs_score
// Sum-of-pairs scorer for multiple-alignment columns with a saturating
// running total.
// ----------------------------------------------------------------------------
// One column request is accepted per clock cycle while the result side does
// not stall, and its result is registered in turn by the pair lanes (one lane
// per row pair, 28 at eight rows) at the accepting edge, by the group and sum
// registers of the adder tree, and by the accumulator, whose 48-bit saturating
// add on the running total is the only loop that a following column waits on.
// Stalls on the result side back up through the four stages, so new columns
// are still taken while empty stages remain. The previous column is captured
// at acceptance, so back-to-back columns see each other for the gap term.
// Configuration is taken in any cycle and must only change while idle.
// ----------------------------------------------------------------------------
module alignment_column_sum_of_pairs_score
  import asps_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
)(
  input  logic                    clk,
  input  logic                    rst,
  // Column requests.
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [BASE_W-1:0]       base_0,
  input  logic [BASE_W-1:0]       base_1,
  input  logic [BASE_W-1:0]       base_2,
  input  logic [BASE_W-1:0]       base_3,
  input  logic [BASE_W-1:0]       base_4,
  input  logic [BASE_W-1:0]       base_5,
  input  logic [BASE_W-1:0]       base_6,
  input  logic [BASE_W-1:0]       base_7,
  input  logic [ROW_CNT-1:0]      row_active,
  input  logic                    first_column,
  input  logic                    score_column,
  input  logic                    restart,
  // Results.
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [COL_W-1:0] column_score,
  output logic signed [TOT_W-1:0] total_score,
  // Configuration writes.
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data
);

  localparam int NPAIRS = MAX_ROWS * (MAX_ROWS - 1) / 2;

  localparam sum_t COL_SAT_MAX = sum_t'(65535);
  localparam sum_t COL_SAT_MIN = sum_t'(-65536);
  localparam logic signed [TOT_W-1:0] TOT_SAT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
  localparam logic signed [TOT_W-1:0] TOT_SAT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  logic [GAPE_W-1:0] gap_extend;
  logic [GAPO_W-1:0] open_penalty;
  logic [BASE_W-1:0] cur         [ROW_CNT];
  logic [BASE_W-1:0] prev_column [ROW_CNT];

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic restart1, restart2, restart3;
  logic scored1, scored2, scored3, scored4;

  lane_ctl_t  lane_ctl;
  merge_ctl_t merge_ctl;
  pair_t      pair_score [NPAIRS];
  sum_t       col_sum;

  logic signed [TOT_W-1:0]   running_total;
  logic signed [TOT_W-1:0]   running_total_next;
  logic signed [TOT_W-1:0]   tot_base;
  logic signed [TOT_W:0]     tot_wide;
  logic signed [COL_W-1:0]   column_score_next;

  assign cur[0] = base_0;
  assign cur[1] = base_1;
  assign cur[2] = base_2;
  assign cur[3] = base_3;
  assign cur[4] = base_4;
  assign cur[5] = base_5;
  assign cur[6] = base_6;
  assign cur[7] = base_7;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_extend   <= GAP_EXTEND_RST;
      open_penalty <= OPEN_PENALTY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GAP_EXTEND:   gap_extend   <= cfg_data[GAPE_W-1:0];
        CFG_OPEN_PENALTY: open_penalty <= cfg_data[GAPO_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage flow control: a stage loads when it is empty or its successor moves.
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Column flags travel alongside the data.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      restart1 <= restart;
      scored1  <= score_column;
    end
    if (rdy2) begin
      restart2 <= restart1;
      scored2  <= scored1;
    end
    if (rdy3) begin
      restart3 <= restart2;
      scored3  <= scored2;
    end
    if (rdy4) begin
      scored4  <= scored3;
    end
  end

  // The accepted column becomes the previous column for the next request.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_CNT; r++) begin
        prev_column[r] <= '0;
      end
    end else if (in_valid && in_ready) begin
      prev_column <= cur;
    end
  end

  // Pair lanes, one for each row pair below MAX_ROWS.
  always_comb begin
    lane_ctl.ld     = rdy1;
    lane_ctl.scored = score_column;
    lane_ctl.first  = first_column;
  end

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    for (genvar s = r + 1; s < MAX_ROWS; s++) begin : g_pair
      localparam int P = r * (2 * MAX_ROWS - r - 1) / 2 + (s - r - 1);
      asps_pair_lane u_lane (
        .clk          (clk),
        .ctl          (lane_ctl),
        .cur_a        (cur[r]),
        .cur_b        (cur[s]),
        .prev_a       (prev_column[r]),
        .prev_b       (prev_column[s]),
        .act_a        (row_active[r]),
        .act_b        (row_active[s]),
        .gap_extend   (gap_extend),
        .open_penalty (open_penalty),
        .score        (pair_score[P])
      );
    end
  end

  // Adder tree over the lanes.
  always_comb begin
    merge_ctl.ld_grp = rdy2;
    merge_ctl.ld_sum = rdy3;
  end

  asps_merge #(
    .NPAIRS (NPAIRS)
  ) u_merge (
    .clk     (clk),
    .ctl     (merge_ctl),
    .pairs   (pair_score),
    .col_sum (col_sum)
  );

  // Accumulate with saturation, and clamp the column score to its field.
  always_comb begin
    tot_base = restart3 ? '0 : running_total;
    tot_wide = {tot_base[TOT_W-1], tot_base} + (TOT_W+1)'(col_sum);
    if (tot_wide[TOT_W] != tot_wide[TOT_W-1]) begin
      running_total_next = tot_wide[TOT_W] ? TOT_SAT_MIN : TOT_SAT_MAX;
    end else begin
      running_total_next = tot_wide[TOT_W-1:0];
    end
    if (col_sum > COL_SAT_MAX) begin
      column_score_next = COL_SAT_MAX[COL_W-1:0];
    end else if (col_sum < COL_SAT_MIN) begin
      column_score_next = COL_SAT_MIN[COL_W-1:0];
    end else begin
      column_score_next = col_sum[COL_W-1:0];
    end
  end

  // Output stage; the running total doubles as the held result.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_total <= '0;
    end else if (rdy4 && v3) begin
      running_total <= running_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      column_score <= column_score_next;
    end
  end

  assign out_valid   = v4;
  assign total_score = running_total;

  // A request is refused only when every stage holds a column and the
  // result is stalled.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && v4 && !out_ready))
    else $error("input refused while the pipeline has room");

  // The running total moves only when a column enters the output stage.
  a_total_holds: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$past(rdy4 && v3)) |-> running_total == $past(running_total))
    else $error("running total changed without a column");

  // A column that is not scored contributes nothing.
  a_unscored_zero: assert property (@(posedge clk) disable iff (rst)
    (v4 && !scored4) |-> column_score == '0)
    else $error("unscored column has a nonzero score");

endmodule

### sv/asps_pair_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asps_pair_lane
// Scores one row pair of a column: substitution plus gap-open penalty,
// registered for the merge stage.
// ----------------------------------------------------------------------------
module asps_pair_lane
  import asps_pkg::*;
(
  input  logic              clk,
  input  lane_ctl_t         ctl,
  input  logic [BASE_W-1:0] cur_a,
  input  logic [BASE_W-1:0] cur_b,
  input  logic [BASE_W-1:0] prev_a,
  input  logic [BASE_W-1:0] prev_b,
  input  logic              act_a,
  input  logic              act_b,
  input  logic [GAPE_W-1:0] gap_extend,
  input  logic [GAPO_W-1:0] open_penalty,
  output pair_t             score
);

  pair_t      score_next;
  pair_t      sub;
  logic [3:0] pat;
  logic       gap_hit;

  // Pair score, zero when the pair does not take part.
  always_comb begin
    sub     = pair_subst(cur_a, cur_b, gap_extend);
    pat     = {prev_a == CH_DASH, prev_b == CH_DASH, cur_a == CH_DASH, cur_b == CH_DASH};
    gap_hit = !ctl.first && GAP_PAT_MASK[pat];
    if (ctl.scored && act_a && act_b) begin
      if (gap_hit) begin
        score_next = sub - pair_t'({{(PAIR_W-GAPO_W){1'b0}}, open_penalty});
      end else begin
        score_next = sub;
      end
    end else begin
      score_next = '0;
    end
  end

  // Lane output register.
  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      score <= score_next;
    end
  end

endmodule

### sv/asps_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asps_merge
// Two-stage registered adder tree that folds the lane scores into one
// column sum.
// ----------------------------------------------------------------------------
module asps_merge
  import asps_pkg::*;
#(
  parameter int NPAIRS = 28
)(
  input  logic       clk,
  input  merge_ctl_t ctl,
  input  pair_t      pairs [NPAIRS],
  output sum_t       col_sum
);

  localparam int NGRP = 4;
  localparam int GSZ  = (NPAIRS + NGRP - 1) / NGRP;

  sum_t grp      [NGRP];
  sum_t grp_next [NGRP];
  sum_t col_sum_next;

  // First level: each group adds a handful of lanes.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_next[g] = '0;
      for (int k = 0; k < GSZ; k++) begin
        if (g * GSZ + k < NPAIRS) begin
          grp_next[g] = grp_next[g] + sum_t'(pairs[g * GSZ + k]);
        end
      end
    end
  end

  // Second level: the group partials.
  always_comb begin
    col_sum_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      col_sum_next = col_sum_next + grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_grp) begin
      grp <= grp_next;
    end
    if (ctl.ld_sum) begin
      col_sum <= col_sum_next;
    end
  end

endmodule
